// ===== rtl/dpdm_pkg.sv =====
// Shared types and constants for the dual PID drive mixer.
package dpdm_pkg;

   localparam int DATA_W     = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int GAIN_W     = 31;
   localparam int LIM_W      = 14;
   localparam int OUT_W      = 16;
   localparam int TURN_ERR_W = 25;
   localparam int KI_W       = 25;
   localparam int FRAC_SHIFT = 14;
   localparam int CLAMP_W    = LIM_W + FRAC_SHIFT + 1;
   localparam int POW_W      = LIM_W + 1;
   localparam int SUM_W      = 66;

   localparam logic [KI_W-1:0]              LAT_INTEG_GAIN  = 25'd0;
   localparam logic [KI_W-1:0]              TURN_INTEG_GAIN = 25'd0;
   localparam logic signed [TURN_ERR_W-1:0] INTEG_BOUND     = 25'sd25;

   localparam logic [DATA_W-1:0] LAT_TARGET_RST      = 32'd0;
   localparam logic [DATA_W-1:0] TURN_TARGET_RST     = 32'd0;
   localparam logic [GAIN_W-1:0] LAT_PROP_GAIN_RST   = 31'd335544;
   localparam logic [GAIN_W-1:0] LAT_DERIV_GAIN_RST  = 31'd1678;
   localparam logic [GAIN_W-1:0] TURN_PROP_GAIN_RST  = 31'd1677722;
   localparam logic [GAIN_W-1:0] TURN_DERIV_GAIN_RST = 31'd1006633;
   localparam logic [LIM_W-1:0]  MAX_LATERAL_RST     = 14'd12083;
   localparam logic [LIM_W-1:0]  MAX_TURN_RST        = 14'd10240;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LATERAL_TARGET  = 3'd0,
      CSR_TURN_TARGET     = 3'd1,
      CSR_LAT_PROP_GAIN   = 3'd2,
      CSR_LAT_DERIV_GAIN  = 3'd3,
      CSR_TURN_PROP_GAIN  = 3'd4,
      CSR_TURN_DERIV_GAIN = 3'd5,
      CSR_MAX_LATERAL     = 3'd6,
      CSR_MAX_TURN        = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic prod_en;
      logic clamp_en;
      logic round_en;
   } pipe_ctl_type;

endpackage

// ===== rtl/dpdm_loop.sv =====
// One PID loop's multiply, sum, clamp and rounding pipeline stages.
module dpdm_loop
   import dpdm_pkg::*;
(
   input  logic                     clock,
   input  pipe_ctl_type             ctl,
   input  logic signed [DATA_W-1:0] err,
   input  logic signed [DATA_W:0]   der,
   input  logic signed [DATA_W-1:0] integ,
   input  logic [GAIN_W-1:0]        prop_gain,
   input  logic [GAIN_W-1:0]        deriv_gain,
   input  logic [KI_W-1:0]          integ_gain,
   input  logic [LIM_W-1:0]         limit,
   output logic signed [POW_W-1:0]  power
);

   localparam int PP_W = DATA_W + GAIN_W + 1;
   localparam int PD_W = DATA_W + GAIN_W + 2;
   localparam int PI_W = DATA_W + KI_W;
   localparam int BOUND_PAD = SUM_W - LIM_W - FRAC_SHIFT;

   logic signed [PP_W-1:0]    prod_p_in, prod_p_ff;
   logic signed [PD_W-1:0]    prod_d_in, prod_d_ff;
   logic signed [PI_W-1:0]    prod_i_in, prod_i_ff;
   logic signed [SUM_W-1:0]   sum;
   logic signed [SUM_W-1:0]   bound_pos;
   logic signed [SUM_W-1:0]   bound_neg;
   logic signed [SUM_W-1:0]   clamped;
   logic signed [CLAMP_W-1:0] clamp_in, clamp_ff;
   logic signed [CLAMP_W-1:0] rounded;
   logic signed [POW_W-1:0]   power_in, power_ff;

   assign prod_p_in = PP_W'(err) * PP_W'($signed({1'b0, prop_gain}));
   assign prod_d_in = PD_W'(der) * PD_W'($signed({1'b0, deriv_gain}));
   assign prod_i_in = PI_W'(integ) * PI_W'($signed({1'b0, integ_gain}));

   always_ff @(posedge clock) begin
      if (ctl.prod_en) begin
         prod_p_ff <= prod_p_in;
         prod_d_ff <= prod_d_in;
         prod_i_ff <= prod_i_in;
      end
   end

   always_comb begin
      sum = {{(SUM_W-PP_W){prod_p_ff[PP_W-1]}}, prod_p_ff}
          + {{(SUM_W-PD_W){prod_d_ff[PD_W-1]}}, prod_d_ff}
          + {{(SUM_W-PI_W){prod_i_ff[PI_W-1]}}, prod_i_ff};
      bound_pos = {{BOUND_PAD{1'b0}}, limit, {FRAC_SHIFT{1'b0}}};
      bound_neg = -bound_pos;
      priority if (sum > bound_pos) begin
         clamped = bound_pos;
      end else if (sum < bound_neg) begin
         clamped = bound_neg;
      end else begin
         clamped = sum;
      end
      clamp_in = clamped[CLAMP_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (ctl.clamp_en) begin
         clamp_ff <= clamp_in;
      end
   end

   // Halves round away from zero, so negative values take one less.
   always_comb begin
      if (clamp_ff[CLAMP_W-1]) begin
         rounded = clamp_ff + CLAMP_W'(8191);
      end else begin
         rounded = clamp_ff + CLAMP_W'(8192);
      end
      power_in = rounded[CLAMP_W-1:FRAC_SHIFT];
   end

   always_ff @(posedge clock) begin
      if (ctl.round_en) begin
         power_ff <= power_in;
      end
   end

   assign power = power_ff;

endmodule

// ===== rtl/dual_pid_drive_mixer.sv =====
// Top level of the dual PID drive mixer: register file, error stages and output mix.
// The block takes one sensor word per clock cycle, unless every stage is full and the result
// channel stalls, and returns one drive word for each through eight register stages, two of
// them around the three multipliers of each loop, the widest of which is 33 by 32 bits.
// Each stage moves on whenever the stage after it is free, so a word is still
// accepted while a finished drive word waits on the result channel, and the input
// stalls only once every stage is full. The target, gain and clamp registers must be
// written while no word is in flight.
module dual_pid_drive_mixer
   import dpdm_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic signed [DATA_W-1:0] req_left_position,
   input  logic signed [DATA_W-1:0] req_right_position,
   input  logic signed [DATA_W-1:0] req_heading,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [OUT_W-1:0]  rsp_left_drive,
   output logic signed [OUT_W-1:0]  rsp_right_drive,
   input  logic                     csr_wr_en,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [DATA_W-1:0]        csr_wdata
);

   localparam int NUM_STAGES = 7;
   localparam int STG_C = 2;
   localparam int STG_D = 3;
   localparam int STG_E = 4;
   localparam int STG_F = 5;
   localparam int STG_G = 6;
   localparam int TGT_W = DATA_W - 8;

   function automatic logic signed [DATA_W-1:0] sat32(input logic signed [DATA_W:0] v);
      logic signed [DATA_W-1:0] r;
      if (v[DATA_W] != v[DATA_W-1]) begin
         r = v[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
      end else begin
         r = v[DATA_W-1:0];
      end
      return r;
   endfunction

   logic signed [DATA_W-1:0] lat_target_ff, turn_target_ff;
   logic [GAIN_W-1:0]        lat_prop_ff, lat_deriv_ff, turn_prop_ff, turn_deriv_ff;
   logic [LIM_W-1:0]         max_lat_ff, max_turn_ff;

   logic [NUM_STAGES-1:0] valid_ff, valid_in;
   logic [NUM_STAGES:0]   adv;
   logic                  rsp_valid_ff;
   logic                  st_en;
   pipe_ctl_type          loop_ctl;

   logic signed [DATA_W-1:0]     left_a_ff, right_a_ff, head_a_ff;
   logic signed [DATA_W:0]       pos_sum;
   logic signed [DATA_W-1:0]     avg_in, avg_b_ff;
   logic signed [DATA_W:0]       turn_diff_in, turn_diff_b_ff;
   logic signed [TGT_W-1:0]      tgt_whole;
   logic signed [DATA_W:0]       lat_dq, lat_raw;
   logic signed [DATA_W:0]       turn_adj;
   logic signed [DATA_W-1:0]     lat_err_in, lat_err_c_ff;
   logic signed [TURN_ERR_W-1:0] turn_err_in, turn_err_c_ff;

   logic signed [DATA_W-1:0]       last_lat_ff, lat_int_ff;
   logic signed [DATA_W:0]         lat_der_ff;
   logic signed [TURN_ERR_W-1:0]   last_turn_ff;
   logic signed [TURN_ERR_W:0]     turn_der_ff;
   logic signed [DATA_W-1:0]       turn_int_ff, turn_int_in;
   logic                           turn_in_bound;

   logic signed [POW_W-1:0] lat_power, turn_power;
   logic signed [OUT_W-1:0] left_drive_ff, right_drive_ff;

   // Register file.
   always_ff @(posedge clock) begin
      if (reset) begin
         lat_target_ff  <= LAT_TARGET_RST;
         turn_target_ff <= TURN_TARGET_RST;
         lat_prop_ff    <= LAT_PROP_GAIN_RST;
         lat_deriv_ff   <= LAT_DERIV_GAIN_RST;
         turn_prop_ff   <= TURN_PROP_GAIN_RST;
         turn_deriv_ff  <= TURN_DERIV_GAIN_RST;
         max_lat_ff     <= MAX_LATERAL_RST;
         max_turn_ff    <= MAX_TURN_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_LATERAL_TARGET:  lat_target_ff  <= csr_wdata;
            CSR_TURN_TARGET:     turn_target_ff <= csr_wdata;
            CSR_LAT_PROP_GAIN:   lat_prop_ff    <= csr_wdata[GAIN_W-1:0];
            CSR_LAT_DERIV_GAIN:  lat_deriv_ff   <= csr_wdata[GAIN_W-1:0];
            CSR_TURN_PROP_GAIN:  turn_prop_ff   <= csr_wdata[GAIN_W-1:0];
            CSR_TURN_DERIV_GAIN: turn_deriv_ff  <= csr_wdata[GAIN_W-1:0];
            CSR_MAX_LATERAL:     max_lat_ff     <= csr_wdata[LIM_W-1:0];
            CSR_MAX_TURN:        max_turn_ff    <= csr_wdata[LIM_W-1:0];
         endcase
      end
   end

   // Pipeline flow control: a stage advances when it is empty or the next one advances.
   always_comb begin
      adv[NUM_STAGES] = !rsp_valid_ff || rsp_ready;
      for (int k = NUM_STAGES - 1; k >= 0; k--) begin
         adv[k] = !valid_ff[k] || adv[k+1];
      end
   end

   assign valid_in = {valid_ff[NUM_STAGES-2:0], req_valid};
   assign req_ready = adv[0];
   assign st_en = adv[STG_D] && valid_ff[STG_C];
   assign loop_ctl = '{prod_en: adv[STG_E], clamp_en: adv[STG_F], round_en: adv[STG_G]};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         for (int k = 0; k < NUM_STAGES; k++) begin
            if (adv[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
         if (adv[NUM_STAGES]) begin
            rsp_valid_ff <= valid_ff[NUM_STAGES-1];
         end
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (adv[0]) begin
         left_a_ff  <= req_left_position;
         right_a_ff <= req_right_position;
         head_a_ff  <= req_heading;
      end
   end

   // Encoder average, truncated towards zero, and raw heading difference.
   always_comb begin
      pos_sum      = {left_a_ff[DATA_W-1], left_a_ff} + {right_a_ff[DATA_W-1], right_a_ff};
      avg_in       = pos_sum[DATA_W:1] + {{(DATA_W-1){1'b0}}, pos_sum[DATA_W] & pos_sum[0]};
      turn_diff_in = {turn_target_ff[DATA_W-1], turn_target_ff}
                   - {head_a_ff[DATA_W-1], head_a_ff};
   end

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         avg_b_ff       <= avg_in;
         turn_diff_b_ff <= turn_diff_in;
      end
   end

   // Errors in whole degrees, truncated towards zero.
   always_comb begin
      tgt_whole = lat_target_ff[DATA_W-1:8];
      lat_dq    = {{(DATA_W+1-TGT_W){tgt_whole[TGT_W-1]}}, tgt_whole}
                - {avg_b_ff[DATA_W-1], avg_b_ff};
      lat_raw   = lat_dq + {{DATA_W{1'b0}},
                            lat_dq[DATA_W] && (lat_target_ff[7:0] != 8'd0)};
      lat_err_in = sat32(lat_raw);
      if (turn_diff_b_ff[DATA_W]) begin
         turn_adj = turn_diff_b_ff + (DATA_W+1)'(255);
      end else begin
         turn_adj = turn_diff_b_ff;
      end
      turn_err_in = turn_adj[DATA_W:8];
   end

   always_ff @(posedge clock) begin
      if (adv[STG_C]) begin
         lat_err_c_ff  <= lat_err_in;
         turn_err_c_ff <= turn_err_in;
      end
   end

   // Loop state: previous errors and integrals move with each word into the next stage.
   always_comb begin
      turn_in_bound = (turn_err_c_ff < INTEG_BOUND) && (turn_err_c_ff > -INTEG_BOUND);
      if (turn_in_bound) begin
         turn_int_in = sat32({turn_int_ff[DATA_W-1], turn_int_ff}
                           + {{(DATA_W+1-TURN_ERR_W){turn_err_c_ff[TURN_ERR_W-1]}},
                              turn_err_c_ff});
      end else begin
         turn_int_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_lat_ff  <= '0;
         lat_int_ff   <= '0;
         last_turn_ff <= '0;
         turn_int_ff  <= '0;
      end else if (st_en) begin
         last_lat_ff  <= lat_err_c_ff;
         lat_int_ff   <= sat32({lat_int_ff[DATA_W-1], lat_int_ff}
                             + {lat_err_c_ff[DATA_W-1], lat_err_c_ff});
         last_turn_ff <= turn_err_c_ff;
         turn_int_ff  <= turn_int_in;
      end
   end

   always_ff @(posedge clock) begin
      if (st_en) begin
         lat_der_ff  <= {lat_err_c_ff[DATA_W-1], lat_err_c_ff}
                      - {last_lat_ff[DATA_W-1], last_lat_ff};
         turn_der_ff <= {turn_err_c_ff[TURN_ERR_W-1], turn_err_c_ff}
                      - {last_turn_ff[TURN_ERR_W-1], last_turn_ff};
      end
   end

   dpdm_loop u_lat_loop (
      .clock      (clock),
      .ctl        (loop_ctl),
      .err        (last_lat_ff),
      .der        (lat_der_ff),
      .integ      (lat_int_ff),
      .prop_gain  (lat_prop_ff),
      .deriv_gain (lat_deriv_ff),
      .integ_gain (LAT_INTEG_GAIN),
      .limit      (max_lat_ff),
      .power      (lat_power)
   );

   dpdm_loop u_turn_loop (
      .clock      (clock),
      .ctl        (loop_ctl),
      .err        ({{(DATA_W-TURN_ERR_W){last_turn_ff[TURN_ERR_W-1]}}, last_turn_ff}),
      .der        ({{(DATA_W-TURN_ERR_W){turn_der_ff[TURN_ERR_W]}}, turn_der_ff}),
      .integ      (turn_int_ff),
      .prop_gain  (turn_prop_ff),
      .deriv_gain (turn_deriv_ff),
      .integ_gain (TURN_INTEG_GAIN),
      .limit      (max_turn_ff),
      .power      (turn_power)
   );

   // Drive mix and result register.
   always_ff @(posedge clock) begin
      if (adv[NUM_STAGES]) begin
         left_drive_ff  <= {lat_power[POW_W-1], lat_power} + {turn_power[POW_W-1], turn_power};
         right_drive_ff <= {lat_power[POW_W-1], lat_power} - {turn_power[POW_W-1], turn_power};
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_left_drive  = left_drive_ff;
   assign rsp_right_drive = right_drive_ff;

   a_full_when_stalled: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> ((&valid_ff) && rsp_valid_ff && !rsp_ready))
      else $error("input stalled while the pipeline has a free stage");

   a_state_holds: assert property (@(posedge clock) disable iff (reset)
      (!st_en) |=> ($stable(last_lat_ff) && $stable(lat_int_ff) && $stable(turn_int_ff)))
      else $error("loop state changed without a word moving");

   a_turn_int_clear: assert property (@(posedge clock) disable iff (reset)
      (st_en && !turn_in_bound) |=> (turn_int_ff == '0))
      else $error("turn integral not cleared on a large error");

   a_rsp_from_pipe: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(valid_ff[NUM_STAGES-1]))
      else $error("result shown without a word in the last stage");

endmodule

// ===== tb/dual_pid_drive_mixer_test.sv =====
// Self-checking testbench for the dual PID drive mixer, with its own model of both control loops.
`timescale 1ns / 1ps

module dual_pid_drive_mixer_test;
   import dpdm_pkg::*;

   typedef struct packed {
      logic signed [OUT_W-1:0] left_drive;
      logic signed [OUT_W-1:0] right_drive;
   } drive_word_type;

   typedef enum int {
      SET_TYPICAL,
      SET_EXTREME,
      SET_WILD
   } setting_style_type;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   logic signed [DATA_W-1:0] req_left_position;
   logic signed [DATA_W-1:0] req_right_position;
   logic signed [DATA_W-1:0] req_heading;
   logic                     rsp_valid;
   logic                     rsp_ready;
   logic signed [OUT_W-1:0]  rsp_left_drive;
   logic signed [OUT_W-1:0]  rsp_right_drive;
   logic                     csr_wr_en;
   logic [CSR_IDX_W-1:0]     csr_index;
   logic [DATA_W-1:0]        csr_wdata;

   // Register and loop state as the controller should hold them.
   logic signed [31:0] m_pos_target  = 32'sd0;
   logic signed [31:0] m_head_target = 32'sd0;
   logic [30:0]        m_pos_kp      = 31'd335544;
   logic [30:0]        m_pos_kd      = 31'd1678;
   logic [30:0]        m_head_kp     = 31'd1677722;
   logic [30:0]        m_head_kd     = 31'd1006633;
   logic [13:0]        m_pos_limit   = 14'd12083;
   logic [13:0]        m_head_limit  = 14'd10240;
   logic signed [31:0] pos_err_prev  = 32'sd0;
   logic signed [31:0] pos_err_sum   = 32'sd0;
   logic signed [31:0] head_err_prev = 32'sd0;
   logic signed [31:0] head_err_sum  = 32'sd0;

   drive_word_type     drive_queue[$];
   drive_word_type     due_drive;
   int                 error_count   = 0;
   int                 send_idle_pct = 20;
   int                 take_idle_pct = 20;
   int                 stall_left    = 0;
   logic signed [31:0] walk_left;
   logic signed [31:0] walk_right;
   logic signed [31:0] walk_head;

   dual_pid_drive_mixer DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_left_position  (req_left_position),
      .req_right_position (req_right_position),
      .req_heading        (req_heading),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_left_drive     (rsp_left_drive),
      .rsp_right_drive    (rsp_right_drive),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("TB_ERROR");
      $finish;
   end

   function automatic int spread(input int span);
      return int'($urandom_range(0, 2 * span)) - span;
   endfunction

   function automatic longint clip32(input longint value);
      if (value > 64'sd2147483647) return 64'sd2147483647;
      if (value < -64'sd2147483648) return -64'sd2147483648;
      return value;
   endfunction

   function automatic logic [31:0] extreme_value();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'h0000_0000;
         3: return 32'hFFFF_FFFF;
         4: return 32'h0000_0001;
         default: return 32'h8000_0001;
      endcase
   endfunction

   // One loop: P, D and I terms in Q.24 volts, clamped, then rounded to Q.10.
   function automatic longint clamp_loop(input longint err, diff, acc, kp, kd, ki, limit);
      logic signed [69:0] e_w, d_w, a_w, p_w, k_w, i_w;
      logic signed [69:0] total, bound, mag, rounded;
      longint q;
      e_w = 70'(err);
      d_w = 70'(diff);
      a_w = 70'(acc);
      p_w = 70'(kp);
      k_w = 70'(kd);
      i_w = 70'(ki);
      bound = 70'(limit);
      bound = bound <<< 14;
      total = e_w * p_w + d_w * k_w + a_w * i_w;
      if (total > bound) total = bound;
      else if (total < -bound) total = -bound;
      mag = (total < 0) ? -total : total;
      rounded = (mag + 70'sd8192) >>> 14;
      q = rounded[63:0];
      return (total < 0) ? -q : q;
   endfunction

   function automatic drive_word_type predict_drive(input logic signed [31:0] left, right, head);
      longint l64, r64, h64, t_pos, t_head, bound;
      longint pos_avg, lat_err, turn_err, lat_sum, turn_sum, lat_pow, turn_pow;
      drive_word_type drive;
      l64 = longint'(left);
      r64 = longint'(right);
      h64 = longint'(head);
      t_pos = longint'(m_pos_target);
      t_head = longint'(m_head_target);
      bound = longint'(INTEG_BOUND);
      pos_avg = (l64 + r64) / 2;
      lat_err = clip32((t_pos - pos_avg * 256) / 256);
      turn_err = (t_head - h64) / 256;
      lat_sum = clip32(pos_err_sum + lat_err);
      if (((turn_err < 0) ? -turn_err : turn_err) < bound) begin
         turn_sum = clip32(head_err_sum + turn_err);
      end else begin
         turn_sum = 0;
      end
      lat_pow = clamp_loop(lat_err, lat_err - pos_err_prev, lat_sum,
                           longint'(m_pos_kp), longint'(m_pos_kd),
                           longint'(LAT_INTEG_GAIN), longint'(m_pos_limit));
      turn_pow = clamp_loop(turn_err, turn_err - head_err_prev, turn_sum,
                            longint'(m_head_kp), longint'(m_head_kd),
                            longint'(TURN_INTEG_GAIN), longint'(m_head_limit));
      pos_err_prev = 32'(lat_err);
      pos_err_sum = 32'(lat_sum);
      head_err_prev = 32'(turn_err);
      head_err_sum = 32'(turn_sum);
      drive.left_drive = 16'(lat_pow + turn_pow);
      drive.right_drive = 16'(lat_pow - turn_pow);
      return drive;
   endfunction

   task automatic send_sample(input logic signed [31:0] left, right, head);
      @(negedge clock);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_left_position <= left;
      req_right_position <= right;
      req_heading <= head;
      do @(posedge clock); while (!req_ready);
      drive_queue.push_back(predict_drive(left, right, head));
   endtask

   task automatic drain_drive_words();
      int waited = 0;
      @(negedge clock);
      req_valid <= 1'b0;
      while (drive_queue.size() != 0 && waited < 2000) begin
         @(posedge clock);
         waited++;
      end
      if (drive_queue.size() != 0) begin
         $error("%0d expected drive words never arrived", drive_queue.size());
         error_count++;
         drive_queue.delete();
      end
      repeat (10) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [31:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      unique case (idx)
         CSR_LATERAL_TARGET:  m_pos_target = value;
         CSR_TURN_TARGET:     m_head_target = value;
         CSR_LAT_PROP_GAIN:   m_pos_kp = value[30:0];
         CSR_LAT_DERIV_GAIN:  m_pos_kd = value[30:0];
         CSR_TURN_PROP_GAIN:  m_head_kp = value[30:0];
         CSR_TURN_DERIV_GAIN: m_head_kd = value[30:0];
         CSR_MAX_LATERAL:     m_pos_limit = value[13:0];
         CSR_MAX_TURN:        m_head_limit = value[13:0];
      endcase
   endtask

   task automatic close_config();
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic load_random_settings(input setting_style_type style);
      csr_index_type idx;
      logic [31:0] value;
      logic high_end;
      for (int i = 0; i < 8; i++) begin
         idx = csr_index_type'(i);
         high_end = $urandom_range(0, 1);
         case (idx)
            CSR_LATERAL_TARGET, CSR_TURN_TARGET: begin
               if (style == SET_TYPICAL) value = spread(1 << 21);
               else value = high_end ? 32'h7FFF_FFFF : 32'h8000_0000;
            end
            CSR_MAX_LATERAL, CSR_MAX_TURN: begin
               if (style == SET_TYPICAL) value = $urandom_range(0, 16383);
               else value = high_end ? 32'hFFFF_FFFF : 32'h0;
            end
            default: begin
               if (style == SET_TYPICAL) value = $urandom_range(0, 1 << 25);
               else value = high_end ? 32'hFFFF_FFFF : 32'h0;
            end
         endcase
         if (style == SET_WILD) value = $urandom;
         write_reg(idx, value);
      end
      close_config();
   endtask

   task automatic seed_walk();
      walk_left = (m_pos_target >>> 8) + spread(50);
      walk_right = walk_left + spread(10);
      walk_head = m_head_target + spread(9000);
   endtask

   // Mostly a smooth track around the targets, with jumps, noise and extreme words.
   task automatic send_random_sample();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
         walk_left = walk_left + spread(20);
         walk_right = walk_right + spread(20);
         walk_head = walk_head + spread(400);
         if ($urandom_range(0, 19) == 0) walk_left = walk_left + spread(5000);
         if ($urandom_range(0, 19) == 0) walk_head = walk_head + spread(20000);
         send_sample(walk_left, walk_right, walk_head);
      end else if (pick < 88) begin
         send_sample($urandom, $urandom, $urandom);
      end else begin
         send_sample(extreme_value(), extreme_value(), extreme_value());
      end
   endtask

   function automatic int pick_idle_pct();
      case ($urandom_range(0, 3))
         0: return 0;
         1: return 10;
         2: return 30;
         default: return 60;
      endcase
   endfunction

   task automatic test_reset_defaults();
      send_sample(32'sd0, 32'sd0, 32'sd0);
      send_sample(32'sd100, 32'sd120, 32'sd5000);
      drain_drive_words();
   endtask

   task automatic test_field_extremes();
      send_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
      send_sample(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
      send_sample(32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
      send_sample(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      send_sample(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000);
      send_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      drain_drive_words();
   endtask

   task automatic test_lateral_saturation();
      write_reg(CSR_LATERAL_TARGET, 32'h8000_0000);
      close_config();
      send_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0);
      send_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0);
      drain_drive_words();
      write_reg(CSR_LATERAL_TARGET, 32'h7FFF_FFFF);
      close_config();
      send_sample(32'h8000_0000, 32'h8000_0000, 32'h0);
      send_sample(32'h8000_0000, 32'h8000_0000, 32'h0);
      drain_drive_words();
   endtask

   task automatic test_turn_bound();
      write_reg(CSR_LATERAL_TARGET, 32'h0);
      write_reg(CSR_TURN_TARGET, 32'h0);
      close_config();
      send_sample(32'sd0, 32'sd0, -32'sd6144);
      send_sample(32'sd0, 32'sd0, -32'sd6400);
      send_sample(32'sd0, 32'sd0, 32'sd6399);
      send_sample(32'sd0, 32'sd0, 32'sd6400);
      send_sample(32'sd0, 32'sd0, -32'sd6399);
      drain_drive_words();
   endtask

   task automatic test_zero_clamp();
      write_reg(CSR_MAX_LATERAL, 32'h0);
      write_reg(CSR_MAX_TURN, 32'h0);
      close_config();
      send_sample(32'sd1000, -32'sd3000, -32'sd90000);
      send_sample(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      drain_drive_words();
   endtask

   task automatic test_round_half();
      write_reg(CSR_LATERAL_TARGET, 32'h0);
      write_reg(CSR_TURN_TARGET, 32'h0);
      write_reg(CSR_LAT_PROP_GAIN, 32'd8192);
      write_reg(CSR_LAT_DERIV_GAIN, 32'h0);
      write_reg(CSR_TURN_PROP_GAIN, 32'h0);
      write_reg(CSR_TURN_DERIV_GAIN, 32'h0);
      write_reg(CSR_MAX_LATERAL, 32'd16383);
      write_reg(CSR_MAX_TURN, 32'd16383);
      close_config();
      send_sample(32'sd1, 32'sd1, 32'sd0);
      send_sample(-32'sd3, -32'sd3, 32'sd0);
      send_sample(32'sd1, 32'sd2, 32'sd0);
      send_sample(-32'sd1, -32'sd2, 32'sd0);
      drain_drive_words();
   endtask

   task automatic test_gain_extremes();
      write_reg(CSR_LATERAL_TARGET, 32'h0);
      write_reg(CSR_TURN_TARGET, 32'h0);
      write_reg(CSR_LAT_PROP_GAIN, 32'hFFFF_FFFF);
      write_reg(CSR_LAT_DERIV_GAIN, 32'hFFFF_FFFF);
      write_reg(CSR_TURN_PROP_GAIN, 32'hFFFF_FFFF);
      write_reg(CSR_TURN_DERIV_GAIN, 32'hFFFF_FFFF);
      write_reg(CSR_MAX_LATERAL, 32'hFFFF_FFFF);
      write_reg(CSR_MAX_TURN, 32'hFFFF_FFFF);
      close_config();
      seed_walk();
      repeat (100) send_random_sample();
      drain_drive_words();
   endtask

   task automatic test_random_phases(input int phases);
      int pick;
      for (int p = 0; p < phases; p++) begin
         pick = $urandom_range(0, 9);
         if (pick < 6) load_random_settings(SET_TYPICAL);
         else if (pick < 8) load_random_settings(SET_EXTREME);
         else load_random_settings(SET_WILD);
         seed_walk();
         send_idle_pct = pick_idle_pct();
         take_idle_pct = pick_idle_pct();
         repeat ($urandom_range(40, 80)) send_random_sample();
         drain_drive_words();
      end
   endtask

   task automatic test_back_to_back();
      send_idle_pct = 0;
      take_idle_pct = 0;
      load_random_settings(SET_TYPICAL);
      seed_walk();
      repeat (120) send_random_sample();
      drain_drive_words();
   endtask

   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else if ($urandom_range(0, 99) < take_idle_pct) begin
            rsp_ready <= 1'b0;
            stall_left = $urandom_range(0, 4);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (drive_queue.size() == 0) begin
            $error("drive word with no expectation: left_drive %0d, right_drive %0d",
                   rsp_left_drive, rsp_right_drive);
            error_count++;
         end else begin
            due_drive = drive_queue.pop_front();
            if (rsp_left_drive !== due_drive.left_drive) begin
               $error("left_drive: expected %0d, actual %0d",
                      due_drive.left_drive, rsp_left_drive);
               error_count++;
            end
            if (rsp_right_drive !== due_drive.right_drive) begin
               $error("right_drive: expected %0d, actual %0d",
                      due_drive.right_drive, rsp_right_drive);
               error_count++;
            end
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_left_position = '0;
      req_right_position = '0;
      req_heading = '0;
      csr_wr_en = 1'b0;
      csr_index = CSR_LATERAL_TARGET;
      csr_wdata = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_field_extremes();
      test_lateral_saturation();
      test_turn_bound();
      test_zero_clamp();
      test_round_half();
      test_gain_extremes();
      test_random_phases(24);
      test_back_to_back();

      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
